// File: rtl/two_level_offset_table_unit_defines.svh
// Assertion macros shared by the offset table RTL.
// Used by the top level only; needs nothing else.
`ifndef TWO_LEVEL_OFFSET_TABLE_UNIT_DEFINES_SVH
`define TWO_LEVEL_OFFSET_TABLE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TLOT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TLOT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tlot_pkg.sv
// Types and constants of the two-level offset table.
// Used by every module of the block; depends on nothing.
package tlot_pkg;

   localparam int MAX_BUCKETS  = 4096;
   localparam int LOW_WIDTH    = 16;
   localparam int VAL_W        = 32;
   localparam int BKT_W        = $clog2(MAX_BUCKETS);
   localparam int CNT_W        = BKT_W + 1;
   localparam int KPB_W        = 16;
   localparam int DIVIDEND_MSB = LOW_WIDTH - 2;
   localparam int G_W          = DIVIDEND_MSB + 1;
   localparam int DIV_CNT_W    = $clog2(G_W);
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = $clog2(QDEPTH);
   localparam int QCNT_W       = QPTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_KEYS  = CSR_IDX_W'(1);

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BUCKETS);
   localparam logic [KPB_W-1:0] KPB_RESET = KPB_W'(4);
   localparam logic [G_W-1:0]   G_RESET   = G_W'((1 << LOW_WIDTH) / (4 * 4));

   localparam logic KIND_INSERT = 1'b0;

   typedef enum logic {
      OP_INSERT,
      OP_LOOKUP
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_FULL,
      ST_OVERFLOW,
      ST_RANGE
   } status_type;

   typedef struct packed {
      logic             kind;
      logic [VAL_W-1:0] index_value;
      logic [VAL_W-1:0] dest_value;
      logic [BKT_W-1:0] bucket_index;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] found_index;
      logic [VAL_W-1:0] found_dest;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [VAL_W-1:0] index_value;
      logic [VAL_W-1:0] dest_value;
      logic [BKT_W-1:0] bucket_index;
   } cmd_type;

   typedef struct packed {
      logic             restart;
      logic             busy;
      logic [CNT_W-1:0] eff_count;
      logic [G_W-1:0]   group_size;
   } cfg_type;

   typedef struct packed {
      logic [BKT_W-1:0]     grp;
      logic [LOW_WIDTH-1:0] diff_index;
      logic [LOW_WIDTH-1:0] diff_dest;
   } low_entry_type;

   typedef struct packed {
      logic [VAL_W-1:0] base_index;
      logic [VAL_W-1:0] base_dest;
   } base_entry_type;

endpackage

// File: rtl/tlot_csr.sv
// Configuration registers and the serial group-size divider.
// Depends on tlot_pkg.
module tlot_csr import tlot_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [CNT_W-1:0]     bucket_count_ff, bucket_count_in;
   logic [KPB_W-1:0]     kpb_ff, kpb_in;
   logic [G_W-1:0]       g_ff, g_in;
   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [KPB_W-1:0]     rem_ff, rem_in;
   logic [G_W-1:0]       quo_ff, quo_in;
   logic                 wr;
   logic [KPB_W-1:0]     den;
   logic [KPB_W:0]       rem_sh;
   logic [KPB_W:0]       rem_sub;
   logic                 ge;
   logic [G_W-1:0]       quo_next;

   assign csr_ready = !busy_ff;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      den      = (kpb_ff == '0) ? KPB_W'(1) : kpb_ff;
      rem_sh   = {rem_ff, (div_cnt_ff == DIV_CNT_W'(DIVIDEND_MSB))};
      rem_sub  = rem_sh - {1'b0, den};
      ge       = (rem_sh >= {1'b0, den});
      quo_next = {quo_ff[G_W-2:0], ge};

      bucket_count_in = bucket_count_ff;
      kpb_in          = kpb_ff;
      g_in            = g_ff;
      busy_in         = busy_ff;
      div_cnt_in      = div_cnt_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;

      if (busy_ff) begin
         rem_in     = ge ? rem_sub[KPB_W-1:0] : rem_sh[KPB_W-1:0];
         quo_in     = quo_next;
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         if (div_cnt_ff == '0) begin
            busy_in = 1'b0;
            g_in    = (quo_next == '0) ? G_W'(1) : quo_next;
         end
      end else if (wr) begin
         unique case (csr_index)
            CSR_BUCKET_COUNT: begin
               bucket_count_in = csr_wdata[CNT_W-1:0];
            end
            CSR_BUCKET_KEYS: begin
               kpb_in     = csr_wdata[KPB_W-1:0];
               busy_in    = 1'b1;
               div_cnt_in = DIV_CNT_W'(DIVIDEND_MSB);
               rem_in     = '0;
               quo_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= '0;
         kpb_ff          <= KPB_RESET;
         g_ff            <= G_RESET;
         busy_ff         <= 1'b0;
         div_cnt_ff      <= '0;
      end else begin
         bucket_count_ff <= bucket_count_in;
         kpb_ff          <= kpb_in;
         g_ff            <= g_in;
         busy_ff         <= busy_in;
         div_cnt_ff      <= div_cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      cfg.restart    = wr && ((csr_index == CSR_BUCKET_COUNT) ||
                              (csr_index == CSR_BUCKET_KEYS));
      cfg.busy       = busy_ff;
      cfg.eff_count  = (bucket_count_ff > MAX_COUNT) ? MAX_COUNT : bucket_count_ff;
      cfg.group_size = g_ff;
   end

endmodule

// File: rtl/tlot_front.sv
// Front end: accept requests, classify them and queue them for the engine.
// Depends on tlot_pkg.
module tlot_front import tlot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    busy,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type             entry;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      entry.op           = (req_data.kind == KIND_INSERT) ? OP_INSERT : OP_LOOKUP;
      entry.index_value  = req_data.index_value;
      entry.dest_value   = req_data.dest_value;
      entry.bucket_index = req_data.bucket_index;
   end

   assign full      = (cnt_ff == QCNT_W'(QDEPTH)) || busy;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: rtl/tlot_back.sv
// Back end: insert and lookup engine with the bucket and group-base memories.
// Depends on tlot_pkg.
module tlot_back import tlot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS,
      S_LK_BASE,
      S_LK_SUM
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cur_ff, cur_in;
   logic [CNT_W-1:0] ins_cnt_ff, ins_cnt_in;
   logic [BKT_W-1:0] ins_grp_ff, ins_grp_in;
   logic [G_W-1:0]   ins_pos_ff, ins_pos_in;

   low_entry_type    low_mem [MAX_BUCKETS];
   base_entry_type   base_mem [MAX_BUCKETS];
   low_entry_type    low_rd_ff;
   base_entry_type   base_rd_ff;
   logic             base_zero_ff, base_zero_in;

   logic             low_re, low_we;
   logic [BKT_W-1:0] low_raddr, low_waddr;
   low_entry_type    low_wdata;
   logic             base_re, base_we;
   logic [BKT_W-1:0] base_raddr, base_waddr;
   base_entry_type   base_wdata;

   base_entry_type   base;
   logic [VAL_W:0]   diff_i, diff_d;
   logic             ovf;
   logic             ins_full;
   logic [G_W-1:0]   pos_next;

   always_comb begin
      base     = base_zero_ff ? '0 : base_rd_ff;
      diff_i   = {1'b0, cur_ff.index_value} - {1'b0, base.base_index};
      diff_d   = {1'b0, cur_ff.dest_value} - {1'b0, base.base_dest};
      ovf      = diff_i[VAL_W] || diff_d[VAL_W] ||
                 (diff_i[VAL_W-1:LOW_WIDTH] != '0) || (diff_d[VAL_W-1:LOW_WIDTH] != '0);
      ins_full = (ins_cnt_ff >= cfg.eff_count);
      pos_next = ins_pos_ff + G_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      ins_cnt_in   = ins_cnt_ff;
      ins_grp_in   = ins_grp_ff;
      ins_pos_in   = ins_pos_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_result   = '{found_index: '0, found_dest: '0, status: ST_OK};
      low_re       = 1'b0;
      low_raddr    = cmd.bucket_index;
      low_we       = 1'b0;
      low_waddr    = ins_cnt_ff[BKT_W-1:0];
      low_wdata    = '{grp: ins_grp_ff, diff_index: diff_i[LOW_WIDTH-1:0],
                       diff_dest: diff_d[LOW_WIDTH-1:0]};
      base_re      = 1'b0;
      base_raddr   = ins_grp_ff - BKT_W'(1);
      base_zero_in = base_zero_ff;
      base_we      = 1'b0;
      base_waddr   = ins_grp_ff;
      base_wdata   = '{base_index: cur_ff.index_value, base_dest: cur_ff.dest_value};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               if (cmd.op == OP_INSERT) begin
                  if (ins_full) begin
                     rsp_push          = 1'b1;
                     rsp_result.status = ST_FULL;
                  end else begin
                     base_re      = (ins_grp_ff != '0);
                     base_zero_in = (ins_grp_ff == '0);
                     state_in     = S_INS;
                  end
               end else begin
                  if ({1'b0, cmd.bucket_index} >= ins_cnt_ff) begin
                     rsp_push          = 1'b1;
                     rsp_result.status = ST_RANGE;
                  end else begin
                     low_re   = 1'b1;
                     state_in = S_LK_BASE;
                  end
               end
            end
         end
         S_INS: begin
            rsp_push = 1'b1;
            state_in = S_IDLE;
            if (ovf) begin
               rsp_result.status = ST_OVERFLOW;
            end else begin
               low_we     = 1'b1;
               base_we    = 1'b1;
               ins_cnt_in = ins_cnt_ff + CNT_W'(1);
               if (pos_next == cfg.group_size) begin
                  ins_pos_in = '0;
                  ins_grp_in = ins_grp_ff + BKT_W'(1);
               end else begin
                  ins_pos_in = pos_next;
               end
            end
         end
         S_LK_BASE: begin
            base_re      = (low_rd_ff.grp != '0);
            base_raddr   = low_rd_ff.grp - BKT_W'(1);
            base_zero_in = (low_rd_ff.grp == '0);
            state_in     = S_LK_SUM;
         end
         S_LK_SUM: begin
            rsp_push               = 1'b1;
            rsp_result.found_index = base.base_index +
                                     {{(VAL_W-LOW_WIDTH){1'b0}}, low_rd_ff.diff_index};
            rsp_result.found_dest  = base.base_dest +
                                     {{(VAL_W-LOW_WIDTH){1'b0}}, low_rd_ff.diff_dest};
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg.restart) begin
         ins_cnt_in = '0;
         ins_grp_in = '0;
         ins_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ins_cnt_ff <= '0;
         ins_grp_ff <= '0;
         ins_pos_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ins_cnt_ff <= ins_cnt_in;
         ins_grp_ff <= ins_grp_in;
         ins_pos_ff <= ins_pos_in;
      end
      cur_ff       <= cur_in;
      base_zero_ff <= base_zero_in;
   end

   always_ff @(posedge clock) begin
      if (low_we) begin
         low_mem[low_waddr] <= low_wdata;
      end
      if (low_re) begin
         low_rd_ff <= low_mem[low_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[base_waddr] <= base_wdata;
      end
      if (base_re) begin
         base_rd_ff <= base_mem[base_raddr];
      end
   end

endmodule

// File: rtl/tlot_rsp_q.sv
// Result queue between the engine and the result port.
// Depends on tlot_pkg.
module tlot_rsp_q import tlot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_data,
   output logic    q_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   rsp_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign q_full   = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign rsp_data = q_ff[rd_ptr_ff];
   assign do_push  = wr_en && !q_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/two_level_offset_table_unit.sv
// Two-level offset table: stores per-bucket offset pairs as differences from a group base.
// Top level; depends on tlot_pkg, tlot_csr, tlot_front, tlot_back, tlot_rsp_q.
//
// Usage:
//   Requests enter through push/full/req_data; a transfer happens when push is high and
//   full is low. Results leave through empty/pop/rsp_data; the oldest result sits on
//   rsp_data while empty is low and transfers when pop is high.
//   Configuration writes use csr_valid/csr_ready/csr_index/csr_wdata while the block is idle.
// The engine takes one request at a time and a new one only in S_IDLE, where it answers a
//   rejected item at once; an insert issues its base read there, then checks and writes
//   in S_INS; a lookup issues its bucket read there, reads the base in S_LK_BASE and adds
//   in S_LK_SUM.
// A bucket-keys write starts a serial divide of the group size; full and csr_ready hold off
//   new transfers until it ends.
// Reset empties both queues and clears the insert count; there is no memory clearing pass.
// When the receiver stalls, results collect in a 2-entry queue and the engine holds the next
//   request once it is full; the 2-entry request queue then fills and raises full.
`include "two_level_offset_table_unit_defines.svh"

module two_level_offset_table_unit import tlot_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type rsp_result;
   logic    keys_wr;
   logic    rsp_fail;
   logic    rsp_zero;

   tlot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tlot_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .busy      (cfg.busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tlot_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_result (rsp_result)
   );

   tlot_rsp_q u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_push),
      .wr_data  (rsp_result),
      .q_full   (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   assign keys_wr  = csr_valid && csr_ready && (csr_index == CSR_BUCKET_KEYS);
   assign rsp_fail = !empty && (rsp_data.status != ST_OK);
   assign rsp_zero = (rsp_data.found_index == '0) && (rsp_data.found_dest == '0);

   `TLOT_ASSERT_SAME(a_rsp_no_overrun, clock, reset, rsp_push, !rsp_full, "result queue overrun")
   `TLOT_ASSERT_SAME(a_cmd_pop_valid, clock, reset, cmd_pop, cmd_valid, "empty request pop")
   `TLOT_ASSERT_NEXT(a_kpb_blocks, clock, reset, keys_wr, full && !csr_ready, "divide not blocking")
   `TLOT_ASSERT_SAME(a_fail_zero, clock, reset, rsp_fail, rsp_zero, "failed result carries data")

endmodule
